>>> src/lrmm_pkg.sv
`default_nettype none
package lrmm_pkg;

    localparam int ORDER  = 10;
    localparam int IDX_W  = 4;
    localparam int BANK_W = 2;
    localparam int COEF_W = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INIT_VAL,
        S_RSTART,
        S_RED,
        S_AFTER,
        S_CHK,
        S_RD,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_SMALL,
        PH_MUL,
        PH_DOT
    } phase_t;

    typedef enum logic [1:0] {
        MD_MULT,
        MD_SQR,
        MD_DOT
    } mode_t;

    typedef struct packed {
        logic  load;
        logic  idx_clr;
        logic  sum_k;
        logic  sum_init;
        logic  red_start;
        logic  red_step;
        logic  init_wr;
        logic  prod_wr;
        logic  entry_inc;
        logic  t_inc;
        logic  mul;
        logic  acc;
        logic  swap;
        logic  e_shift;
        logic  out_load;
        logic  out_zero;
        mode_t mode;
    } cmd_t;

    typedef struct packed {
        logic md_zero;
        logic k_small;
        logic red_last;
        logic last_entry;
        logic last_t;
        logic mat_last;
        logic e_one;
        logic e_lsb;
    } sts_t;

endpackage
`default_nettype wire

>>> src/lrmm_ram.sv
`default_nettype none
module lrmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

>>> src/lrmm_datapath.sv
`default_nettype none
module lrmm_datapath #(
    parameter int MOD_BITS = 16,
    parameter int EXP_BITS = 31
) (
    input  wire logic                       aclk,
    input  wire lrmm_pkg::cmd_t             cmd,
    output lrmm_pkg::sts_t                  sts,
    input  wire logic [EXP_BITS-1:0]        index_k,
    input  wire logic [MOD_BITS-1:0]        modulus,
    input  wire logic [lrmm_pkg::COEF_W-1:0] coef [lrmm_pkg::ORDER],
    output logic      [MOD_BITS-1:0]        term_value
);

    localparam int OPB_W  = (MOD_BITS > 4) ? MOD_BITS : 4;
    localparam int PROD_W = MOD_BITS + OPB_W;
    localparam int W0     = (EXP_BITS > 2 * MOD_BITS + 4) ? EXP_BITS : 2 * MOD_BITS + 4;
    localparam int ACC_W  = (W0 > lrmm_pkg::COEF_W) ? W0 : lrmm_pkg::COEF_W;
    localparam int CNT_W  = $clog2(ACC_W);
    localparam int ADDR_W = lrmm_pkg::BANK_W + 2 * lrmm_pkg::IDX_W;

    logic [EXP_BITS-1:0]         e_reg;
    logic [MOD_BITS-1:0]         md_reg;
    logic [lrmm_pkg::COEF_W-1:0] coef_reg [lrmm_pkg::ORDER];
    logic [lrmm_pkg::BANK_W-1:0] base_bank_reg, acc_bank_reg, free_bank_reg;
    logic [lrmm_pkg::IDX_W-1:0]  r_reg, c_reg, t_reg;
    logic                        m_reg;
    logic                        md_zero_reg, k_small_reg;
    logic [ACC_W-1:0]            sum_reg;
    logic [ACC_W-1:0]            sh_reg;
    logic [MOD_BITS-1:0]         rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [MOD_BITS-1:0]         result_reg;

    logic [MOD_BITS:0]           trial;
    logic [ACC_W-1:0]            init_val;
    logic [OPB_W-1:0]            opb;
    logic                        we;
    logic [ADDR_W-1:0]           waddr, raddr_a, raddr_b;
    logic [lrmm_pkg::BANK_W-1:0] wbank, abank;
    logic [MOD_BITS-1:0]         rdata_a, rdata_b;

    lrmm_ram #(
        .WIDTH (MOD_BITS),
        .DEPTH (1 << ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (rem_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb begin
        trial = {rem_reg, sh_reg[ACC_W-1]};
        if (m_reg) begin
            init_val = (r_reg == c_reg) ? ACC_W'(1) : '0;
        end else if (r_reg == '0) begin
            init_val = ACC_W'(coef_reg[c_reg]);
        end else begin
            init_val = (r_reg == c_reg + 4'd1) ? ACC_W'(1) : '0;
        end
        if (cmd.mode == lrmm_pkg::MD_DOT) begin
            opb = OPB_W'(4'(lrmm_pkg::ORDER - 1) - t_reg);
        end else begin
            opb = OPB_W'(rdata_b);
        end
        we      = cmd.init_wr | cmd.prod_wr;
        wbank   = cmd.init_wr ? (m_reg ? acc_bank_reg : base_bank_reg) : free_bank_reg;
        waddr   = {wbank, r_reg, c_reg};
        abank   = (cmd.mode == lrmm_pkg::MD_SQR) ? base_bank_reg : acc_bank_reg;
        raddr_a = {abank, r_reg, t_reg};
        raddr_b = {base_bank_reg, t_reg, c_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            e_reg         <= index_k - EXP_BITS'(lrmm_pkg::ORDER - 1);
            md_reg        <= modulus;
            md_zero_reg   <= (modulus == '0);
            k_small_reg   <= (index_k < EXP_BITS'(lrmm_pkg::ORDER));
            coef_reg      <= coef;
            base_bank_reg <= 2'd0;
            acc_bank_reg  <= 2'd1;
            free_bank_reg <= 2'd2;
            m_reg         <= 1'b0;
            sum_reg       <= ACC_W'(index_k);
        end
        if (cmd.idx_clr) begin
            r_reg <= '0;
            c_reg <= '0;
            t_reg <= '0;
        end
        if (cmd.sum_k) begin
            sum_reg <= ACC_W'(e_reg) + ACC_W'(lrmm_pkg::ORDER - 1);
        end
        if (cmd.sum_init) begin
            sum_reg <= init_val;
        end
        if (cmd.red_start) begin
            sh_reg  <= sum_reg;
            sum_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.red_step) begin
            sh_reg  <= sh_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (trial >= {1'b0, md_reg}) begin
                rem_reg <= MOD_BITS'(trial - {1'b0, md_reg});
            end else begin
                rem_reg <= MOD_BITS'(trial);
            end
        end
        if (cmd.init_wr && r_reg == 4'(lrmm_pkg::ORDER - 1)
                && c_reg == 4'(lrmm_pkg::ORDER - 1)) begin
            m_reg <= 1'b1;
        end
        if (cmd.entry_inc) begin
            if (c_reg == 4'(lrmm_pkg::ORDER - 1)) begin
                c_reg <= '0;
                r_reg <= (r_reg == 4'(lrmm_pkg::ORDER - 1)) ? '0 : r_reg + 4'd1;
            end else begin
                c_reg <= c_reg + 4'd1;
            end
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(rdata_a) * PROD_W'(opb);
        end
        if (cmd.acc) begin
            sum_reg <= sum_reg + ACC_W'(prod_reg);
        end
        if (cmd.t_inc) begin
            t_reg <= (t_reg == 4'(lrmm_pkg::ORDER - 1)) ? '0 : t_reg + 4'd1;
        end
        if (cmd.swap) begin
            free_bank_reg <= (cmd.mode == lrmm_pkg::MD_SQR) ? base_bank_reg : acc_bank_reg;
            if (cmd.mode == lrmm_pkg::MD_SQR) begin
                base_bank_reg <= free_bank_reg;
            end else begin
                acc_bank_reg <= free_bank_reg;
            end
        end
        if (cmd.e_shift) begin
            e_reg <= e_reg >> 1;
        end
        if (cmd.out_load) begin
            result_reg <= rem_reg;
        end
        if (cmd.out_zero) begin
            result_reg <= '0;
        end
    end

    always_comb begin
        sts.md_zero    = md_zero_reg;
        sts.k_small    = k_small_reg;
        sts.red_last   = (cnt_reg == CNT_W'(ACC_W - 1));
        sts.last_entry = (r_reg == 4'(lrmm_pkg::ORDER - 1))
                       && (c_reg == 4'(lrmm_pkg::ORDER - 1));
        sts.last_t     = (t_reg == 4'(lrmm_pkg::ORDER - 1));
        sts.mat_last   = m_reg;
        sts.e_one      = (e_reg == EXP_BITS'(1));
        sts.e_lsb      = e_reg[0];
    end

    assign term_value = result_reg;

endmodule
`default_nettype wire

>>> src/lrmm_ctrl.sv
`default_nettype none
module lrmm_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lrmm_pkg::cmd_t      cmd,
    input  wire lrmm_pkg::sts_t sts
);

    lrmm_pkg::state_t state_reg, state_next;
    lrmm_pkg::phase_t phase_reg, phase_next;
    lrmm_pkg::mode_t  kind_reg, kind_next;
    logic             did_reg, did_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrmm_pkg::S_IDLE;
            phase_reg <= lrmm_pkg::PH_INIT;
            kind_reg  <= lrmm_pkg::MD_MULT;
            did_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            did_reg   <= did_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        did_next   = did_reg;
        case (state_reg)
            lrmm_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = lrmm_pkg::S_LOAD;
                end
            end
            lrmm_pkg::S_LOAD: begin
                did_next = 1'b0;
                if (sts.md_zero) begin
                    state_next = lrmm_pkg::S_OUT;
                end else if (sts.k_small) begin
                    phase_next = lrmm_pkg::PH_SMALL;
                    state_next = lrmm_pkg::S_RSTART;
                end else begin
                    phase_next = lrmm_pkg::PH_INIT;
                    state_next = lrmm_pkg::S_INIT_VAL;
                end
            end
            lrmm_pkg::S_INIT_VAL: state_next = lrmm_pkg::S_RSTART;
            lrmm_pkg::S_RSTART:   state_next = lrmm_pkg::S_RED;
            lrmm_pkg::S_RED: begin
                if (sts.red_last) begin
                    state_next = lrmm_pkg::S_AFTER;
                end
            end
            lrmm_pkg::S_AFTER: begin
                case (phase_reg)
                    lrmm_pkg::PH_INIT: begin
                        if (sts.last_entry && sts.mat_last) begin
                            state_next = lrmm_pkg::S_CHK;
                        end else begin
                            state_next = lrmm_pkg::S_INIT_VAL;
                        end
                    end
                    lrmm_pkg::PH_MUL: begin
                        if (sts.last_entry) begin
                            did_next   = (kind_reg == lrmm_pkg::MD_MULT);
                            state_next = lrmm_pkg::S_CHK;
                        end else begin
                            state_next = lrmm_pkg::S_RD;
                        end
                    end
                    default: state_next = lrmm_pkg::S_OUT;
                endcase
            end
            lrmm_pkg::S_CHK: begin
                state_next = lrmm_pkg::S_RD;
                if (sts.e_lsb && !did_reg) begin
                    phase_next = lrmm_pkg::PH_MUL;
                    kind_next  = lrmm_pkg::MD_MULT;
                end else if (sts.e_one) begin
                    phase_next = lrmm_pkg::PH_DOT;
                    kind_next  = lrmm_pkg::MD_DOT;
                end else begin
                    phase_next = lrmm_pkg::PH_MUL;
                    kind_next  = lrmm_pkg::MD_SQR;
                end
            end
            lrmm_pkg::S_RD:  state_next = lrmm_pkg::S_MUL;
            lrmm_pkg::S_MUL: state_next = lrmm_pkg::S_ACC;
            lrmm_pkg::S_ACC: begin
                state_next = sts.last_t ? lrmm_pkg::S_RSTART : lrmm_pkg::S_RD;
            end
            lrmm_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = lrmm_pkg::S_IDLE;
                end
            end
            default: state_next = lrmm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.mode = kind_reg;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        case (state_reg)
            lrmm_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.idx_clr = s_valid;
            end
            lrmm_pkg::S_LOAD: begin
                cmd.out_zero = sts.md_zero;
            end
            lrmm_pkg::S_INIT_VAL: cmd.sum_init  = 1'b1;
            lrmm_pkg::S_RSTART:   cmd.red_start = 1'b1;
            lrmm_pkg::S_RED:      cmd.red_step  = 1'b1;
            lrmm_pkg::S_AFTER: begin
                case (phase_reg)
                    lrmm_pkg::PH_INIT: begin
                        cmd.init_wr   = 1'b1;
                        cmd.entry_inc = 1'b1;
                    end
                    lrmm_pkg::PH_MUL: begin
                        cmd.prod_wr   = 1'b1;
                        cmd.entry_inc = 1'b1;
                        cmd.swap      = sts.last_entry;
                        cmd.e_shift   = sts.last_entry && (kind_reg == lrmm_pkg::MD_SQR);
                    end
                    default: cmd.out_load = 1'b1;
                endcase
            end
            lrmm_pkg::S_CHK: cmd.idx_clr = 1'b1;
            lrmm_pkg::S_RD:  cmd.sum_k   = 1'b0;
            lrmm_pkg::S_MUL: cmd.mul     = 1'b1;
            lrmm_pkg::S_ACC: begin
                cmd.acc   = 1'b1;
                cmd.t_inc = 1'b1;
            end
            lrmm_pkg::S_OUT: m_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> src/linear_recurrence_mod_matpow.sv
// Order-ten linear recurrence f(k) mod modulus, by companion matrix powering.
// Input channel s_*: one item carries index_k, modulus and coef_0..coef_9;
// it is taken when s_valid and s_ready are both high. Result channel m_*:
// m_term_value is held with m_valid until m_ready is seen high.
// One item is in work at a time; s_ready is high only while idle.
// Every entry of a matrix product is a ten-term sum from one multiplier, each term
// taken through read, multiply and accumulate, followed by a bit-serial remainder
// over the ACC_W bits of the sum, where ACC_W = max(EXP_BITS, 2*MOD_BITS+4, 16)
// (36 at the defaults); a matrix product has 100 entries.
// Work from accept to m_valid: a zero modulus gives zero directly; index_k below
// ten takes a single remainder; otherwise the two start matrices are loaded
// (200 entries), then comes one product per set bit of index_k-9 plus one
// per bit position above the lowest, at most 2*EXP_BITS-1 products, then the
// final dot product.
// A stalled receiver holds the result and keeps s_ready low.
// aresetn is synchronous and active low; it returns the block to idle.
`default_nettype none
module linear_recurrence_mod_matpow #(
    parameter int MOD_BITS = 16,
    parameter int EXP_BITS = 31
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [EXP_BITS-1:0]          s_index_k,
    input  wire logic [MOD_BITS-1:0]          s_modulus,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_0,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_1,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_2,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_3,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_4,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_5,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_6,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_7,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_8,
    input  wire logic [lrmm_pkg::COEF_W-1:0]  s_coef_9,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [MOD_BITS-1:0]          m_term_value
);

    lrmm_pkg::cmd_t              cmd;
    lrmm_pkg::sts_t              sts;
    logic [lrmm_pkg::COEF_W-1:0] coef [lrmm_pkg::ORDER];

    always_comb begin
        coef[0] = s_coef_0;
        coef[1] = s_coef_1;
        coef[2] = s_coef_2;
        coef[3] = s_coef_3;
        coef[4] = s_coef_4;
        coef[5] = s_coef_5;
        coef[6] = s_coef_6;
        coef[7] = s_coef_7;
        coef[8] = s_coef_8;
        coef[9] = s_coef_9;
    end

    lrmm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lrmm_datapath #(
        .MOD_BITS (MOD_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .sts        (sts),
        .index_k    (s_index_k),
        .modulus    (s_modulus),
        .coef       (coef),
        .term_value (m_term_value)
    );

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int ORDER = lrmm_pkg::ORDER;
    localparam int COEF_W = lrmm_pkg::COEF_W;
    localparam int K_W = 31;
    localparam int M_W = 16;
    localparam longint LIMIT = 120_000_000;

    typedef struct packed {
        logic [K_W-1:0] k;
        logic [M_W-1:0] md;
        logic [ORDER-1:0][COEF_W-1:0] cf;
    } term_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [K_W-1:0] s_index_k = '0;
    logic [M_W-1:0] s_modulus = '0;
    logic [ORDER-1:0][COEF_W-1:0] s_coef = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [M_W-1:0] m_term_value;

    term_req_t pending_reqs[$];
    logic [M_W-1:0] want_terms[$];
    int fails = 0;
    int taken = 0;
    int got = 0;
    int gap = 0;
    int hold_off = 0;
    bit held = 0;
    bit took = 0;
    longint cycles = 0;
    longint unsigned mats[2][ORDER][ORDER];
    longint unsigned prod[ORDER][ORDER];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    linear_recurrence_mod_matpow u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_index_k(s_index_k), .s_modulus(s_modulus),
        .s_coef_0(s_coef[0]), .s_coef_1(s_coef[1]), .s_coef_2(s_coef[2]),
        .s_coef_3(s_coef[3]), .s_coef_4(s_coef[4]), .s_coef_5(s_coef[5]),
        .s_coef_6(s_coef[6]), .s_coef_7(s_coef[7]), .s_coef_8(s_coef[8]),
        .s_coef_9(s_coef[9]),
        .m_valid(m_valid), .m_ready(m_ready), .m_term_value(m_term_value)
    );

    // mats[0] is the running power of the companion matrix, mats[1] the product
    function automatic logic [M_W-1:0] term_mod(term_req_t rq);
        longint unsigned md, e, sum;
        int d;
        md = 64'(rq.md);
        if (md == 0) return '0;
        if (rq.k < ORDER) return M_W'(64'(rq.k) % md);
        for (int r = 0; r < ORDER; r++) begin
            for (int c = 0; c < ORDER; c++) begin
                if (r == 0) mats[0][r][c] = 64'(rq.cf[c]) % md;
                else mats[0][r][c] = (r - 1 == c) ? 64'(1) % md : 64'(0);
                mats[1][r][c] = (r == c) ? 64'(1) % md : 64'(0);
            end
        end
        e = 64'(rq.k) - 64'(ORDER - 1);
        while (e != 0) begin
            for (int step = 0; step < 2; step++) begin
                d = (step == 0) ? 1 : 0;
                if (step == 0 && !e[0]) continue;
                for (int r = 0; r < ORDER; r++) begin
                    for (int c = 0; c < ORDER; c++) begin
                        sum = 0;
                        for (int t = 0; t < ORDER; t++)
                            sum += (mats[d][r][t] * mats[0][t][c]) % md;
                        prod[r][c] = sum % md;
                    end
                end
                for (int r = 0; r < ORDER; r++)
                    for (int c = 0; c < ORDER; c++) mats[d][r][c] = prod[r][c];
            end
            e >>= 1;
        end
        sum = 0;
        for (int c = 0; c < ORDER; c++)
            sum += (mats[1][0][c] * 64'(ORDER - 1 - c)) % md;
        return M_W'(sum % md);
    endfunction

    function automatic term_req_t make_req(logic [K_W-1:0] k, logic [M_W-1:0] md,
                                           logic [COEF_W-1:0] fill, bit rnd);
        term_req_t rq;
        rq.k = k;
        rq.md = md;
        for (int i = 0; i < ORDER; i++) rq.cf[i] = rnd ? COEF_W'($urandom) : fill;
        return rq;
    endfunction

    // driver
    always @(negedge aclk) begin
        logic nv;
        term_req_t rq;
        nv = s_valid;
        if (aresetn && (!s_valid || took)) begin
            nv = 1'b0;
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_index_k <= rq.k;
                s_modulus <= rq.md;
                s_coef <= rq.cf;
                nv = 1'b1;
                if ($urandom_range(0, 3) == 0) gap <= int'($urandom_range(1, 40));
            end
        end
        s_valid <= nv;
    end

    // receiver
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (got == 5 && !held) begin
            held = 1;
            hold_off <= 3000;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycles[14:12] == 3'd0) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles++;
        took = s_valid && s_ready;
        if (aresetn && took) begin
            want_terms.push_back(term_mod({s_index_k, s_modulus, s_coef}));
            taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            got++;
            if (want_terms.size() == 0) begin
                $error("unexpected term_value %0d", m_term_value);
                fails++;
            end else if (want_terms[0] !== m_term_value) begin
                $error("term_value: expected %0d, actual %0d", want_terms[0], m_term_value);
                fails++;
                void'(want_terms.pop_front());
            end else begin
                void'(want_terms.pop_front());
            end
        end
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        logic [K_W-1:0] k;
        logic [M_W-1:0] md;
        pending_reqs.push_back(make_req(0, 0, 16'h1234, 0));
        pending_reqs.push_back(make_req(5, 0, 0, 0));
        pending_reqs.push_back(make_req('1, 0, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(9, 16'hFFFF, 0, 0));
        pending_reqs.push_back(make_req(7, 1, 0, 0));
        pending_reqs.push_back(make_req(3, 2, 0, 0));
        pending_reqs.push_back(make_req(10, 16'hFFFF, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(11, 1, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(12, 2, 0, 0));
        pending_reqs.push_back(make_req(13, 7, 1, 0));
        pending_reqs.push_back(make_req(20, 16'd65521, 0, 1));
        pending_reqs.push_back(make_req(25, 16'h8000, 0, 1));
        pending_reqs.push_back(make_req('1, 16'hFFFF, 16'hFFFF, 0));
        for (int i = 0; i < 100; i++) begin
            n = int'($urandom_range(0, 19));
            if (n < 8) k = K_W'($urandom_range(0, 9));
            else if (n < 18) k = K_W'($urandom_range(10, 26));
            else if (n < 19) k = K_W'($urandom_range(27, 300));
            else k = (i % 3 == 0) ? K_W'($urandom) : K_W'($urandom_range(300, 5000));
            n = int'($urandom_range(0, 9));
            if (n == 0) md = M_W'($urandom_range(1, 3));
            else if (n == 1) md = 16'hFFFF;
            else md = M_W'($urandom_range(1, 65535));
            pending_reqs.push_back(make_req(k, md, 0, 1));
        end
        n = pending_reqs.size();
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;
        while (taken < n || want_terms.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/lrmm_pkg.sv
src/lrmm_ram.sv
src/lrmm_datapath.sv
src/lrmm_ctrl.sv
src/linear_recurrence_mod_matpow.sv
bench/tb.sv
